// ----- rtl/dfu_pkg.sv -----
// shared types and constants for the dfu request state machine
// no dependencies; imported by every rtl module and the checker
package dfu_pkg;

    // dfu device states
    typedef enum logic [3:0] {
        ST_APP_IDLE   = 4'd0,
        ST_APP_DETACH = 4'd1,
        ST_IDLE       = 4'd2,
        ST_DN_SYNC    = 4'd3,
        ST_DN_BUSY    = 4'd4,
        ST_DN_IDLE    = 4'd5,
        ST_MAN_SYNC   = 4'd6,
        ST_MANIFEST   = 4'd7,
        ST_WAIT_RESET = 4'd8,
        ST_UP_IDLE    = 4'd9,
        ST_ERROR      = 4'd10
    } dfu_state_t;

    // status codes reported to the host
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOTDONE = 2'd1,
        STS_STALL   = 2'd2
    } status_t;

    // request and event codes
    typedef enum logic [3:0] {
        RQ_DNLOAD    = 4'd0,
        RQ_UPLOAD    = 4'd1,
        RQ_GETSTATUS = 4'd2,
        RQ_CLRSTATUS = 4'd3,
        RQ_GETSTATE  = 4'd4,
        RQ_ABORT     = 4'd5,
        RQ_OTHER     = 4'd6,
        EV_BUS_RESET = 4'd7,
        EV_WR_BEGIN  = 4'd8,
        EV_WR_DONE   = 4'd9
    } req_t;

    // flash copy progress lock
    typedef enum logic [1:0] {
        LK_WAIT   = 2'd0,
        LK_BEGIN  = 2'd1,
        LK_MIDDLE = 2'd2,
        LK_END    = 2'd3
    } lock_t;

    // configuration register indexes
    typedef enum logic {
        CFG_RAM_BASE   = 1'b0,
        CFG_FLASH_BASE = 1'b1
    } cfg_index_t;

    localparam logic [8:0] TIMEOUT_FULL = 9'h1FF;
    localparam logic [8:0] TIMEOUT_KEEP = 9'h100;

    // one registered request
    typedef struct packed {
        logic [3:0]  req_type;
        logic [10:0] block_length;
        logic        alt_setting;
    } dfu_req_t;

    // one result
    typedef struct packed {
        dfu_state_t  state;
        status_t     status;
        logic        ok;
        logic [8:0]  timeout;
        logic        copy_to_ram;
        logic        flash_unlock;
        logic        flash_relock;
        logic        flash_write_start;
        logic [31:0] write_address;
        logic [10:0] write_length;
        logic        hard_reset;
    } dfu_result_t;

endpackage

// ----- rtl/dfu_in_reg.sv -----
// input register stage: holds one accepted request until the fsm takes it
// depends on dfu_pkg
module dfu_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfu_pkg::dfu_req_t req_in,
    input  logic              advance,
    output logic              s1_valid,
    output dfu_pkg::dfu_req_t req_out
);
    import dfu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dfu_req_t req_reg;
    logic     accept;

    // slot is free when empty or draining this cycle
    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req_in;
    end

    assign s1_valid = valid_reg;
    assign req_out  = req_reg;

endmodule

// ----- rtl/dfu_fsm.sv -----
// dfu state machine: state registers, configuration registers and the
// combinational transition and result logic; depends on dfu_pkg
module dfu_fsm #(
    parameter int MAX_BLOCK = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 advance,
    input  dfu_pkg::dfu_req_t    req,
    output dfu_pkg::dfu_result_t result
);
    import dfu_pkg::*;

    logic [31:0] ram_base_reg;
    logic [31:0] flash_base_reg;

    dfu_state_t  state_reg,  state_next;
    status_t     status_reg, status_next;
    logic [8:0]  timeout_reg, timeout_next;
    logic        target_reg, target_next;
    lock_t       lock_reg,   lock_next;
    logic [31:0] fwlen_reg,  fwlen_next;
    logic [10:0] bbytes_reg, bbytes_next;

    req_t        rq;
    logic [10:0] clamped;
    logic [31:0] fwlen_sum;
    logic        p_ram, p_unlock, p_relock, p_wstart, p_hard;
    logic [31:0] waddr;
    logic [10:0] wlen;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg   <= '0;
            flash_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RAM_BASE:   ram_base_reg   <= cfg_data;
                CFG_FLASH_BASE: flash_base_reg <= cfg_data;
                default:        ram_base_reg   <= ram_base_reg;
            endcase
        end
    end

    // request decode, block length saturation, length accumulate
    assign rq        = (req.req_type > 4'(EV_WR_DONE)) ? RQ_OTHER : req_t'(req.req_type);
    assign clamped   = (32'(req.block_length) > 32'(MAX_BLOCK)) ? 11'(MAX_BLOCK)
                                                                 : req.block_length;
    assign fwlen_sum = fwlen_reg + 32'(bbytes_reg);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        timeout_next = timeout_reg;
        target_next  = target_reg;
        lock_next    = lock_reg;
        fwlen_next   = fwlen_reg;
        bbytes_next  = bbytes_reg;
        unique case (rq)
            EV_BUS_RESET:
            begin
                fwlen_next = '0;
                if (state_reg != ST_APP_IDLE && state_reg != ST_IDLE)
                begin
                    state_next  = ST_IDLE;
                    status_next = STS_OK;
                end
            end
            EV_WR_BEGIN:
            begin
                if (target_reg && lock_reg == LK_BEGIN)
                    lock_next = LK_MIDDLE;
            end
            EV_WR_DONE:
            begin
                if (target_reg && lock_reg == LK_MIDDLE)
                begin
                    fwlen_next  = fwlen_sum;
                    bbytes_next = '0;
                    lock_next   = LK_END;
                end
            end
            default:
            begin
                status_next = STS_OK;
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (rq == RQ_DNLOAD)
                        begin
                            if (req.block_length != '0)
                            begin
                                fwlen_next  = '0;
                                bbytes_next = clamped;
                                state_next  = ST_DN_SYNC;
                                target_next = req.alt_setting;
                            end
                            else
                            begin
                                state_next  = ST_ERROR;
                                status_next = STS_NOTDONE;
                            end
                        end
                        else if (rq == RQ_UPLOAD)
                            state_next = ST_UP_IDLE;
                        else if (rq inside {RQ_ABORT, RQ_GETSTATUS, RQ_GETSTATE})
                            state_next = ST_IDLE;
                        else
                        begin
                            state_next  = ST_ERROR;
                            status_next = STS_STALL;
                        end
                    end
                    ST_DN_SYNC:
                    begin
                        if (rq == RQ_GETSTATUS)
                        begin
                            if (target_reg)
                            begin
                                if (lock_reg == LK_WAIT)
                                begin
                                    lock_next    = LK_BEGIN;
                                    timeout_next = TIMEOUT_FULL;
                                    state_next   = ST_DN_BUSY;
                                end
                                else if (lock_reg == LK_END)
                                begin
                                    timeout_next = timeout_reg & TIMEOUT_KEEP;
                                    lock_next    = LK_WAIT;
                                    state_next   = ST_DN_IDLE;
                                end
                            end
                            else
                            begin
                                state_next  = ST_DN_IDLE;
                                fwlen_next  = fwlen_sum;
                                bbytes_next = '0;
                            end
                        end
                        else if (rq != RQ_GETSTATE)
                        begin
                            state_next  = ST_ERROR;
                            status_next = STS_STALL;
                        end
                    end
                    ST_DN_BUSY:
                    begin
                        if (lock_reg == LK_END)
                        begin
                            timeout_next = timeout_reg & TIMEOUT_KEEP;
                            lock_next    = LK_WAIT;
                            state_next   = ST_DN_IDLE;
                        end
                    end
                    ST_DN_IDLE:
                    begin
                        if (rq == RQ_DNLOAD)
                        begin
                            if (req.block_length != '0)
                            begin
                                bbytes_next = clamped;
                                state_next  = ST_DN_SYNC;
                            end
                            else
                                state_next = ST_MAN_SYNC;
                        end
                        else if (rq inside {RQ_ABORT, RQ_GETSTATUS, RQ_GETSTATE})
                            state_next = ST_IDLE;
                        else
                        begin
                            state_next  = ST_ERROR;
                            status_next = STS_STALL;
                        end
                    end
                    ST_MAN_SYNC:
                    begin
                        if (rq == RQ_GETSTATUS)
                            state_next = ST_WAIT_RESET;
                        else if (rq != RQ_GETSTATE)
                        begin
                            state_next  = ST_ERROR;
                            status_next = STS_STALL;
                        end
                    end
                    ST_MANIFEST:
                        state_next = ST_WAIT_RESET;
                    ST_WAIT_RESET:
                        state_next = ST_WAIT_RESET;
                    ST_UP_IDLE:
                    begin
                        if (rq == RQ_ABORT)
                            state_next = ST_IDLE;
                        else if (rq != RQ_GETSTATUS && rq != RQ_GETSTATE)
                        begin
                            state_next  = ST_ERROR;
                            status_next = STS_STALL;
                        end
                    end
                    ST_ERROR:
                    begin
                        if (rq == RQ_CLRSTATUS)
                            state_next = ST_IDLE;
                        else if (rq != RQ_GETSTATUS && rq != RQ_GETSTATE)
                            status_next = STS_STALL;
                    end
                    default:
                    begin
                        // app states and unknown codes reject class requests
                        state_next  = ST_ERROR;
                        status_next = STS_STALL;
                    end
                endcase
            end
        endcase
    end

    // pulse and write window outputs
    always_comb
    begin
        p_ram    = 1'b0;
        p_unlock = 1'b0;
        p_relock = 1'b0;
        p_wstart = 1'b0;
        p_hard   = 1'b0;
        waddr    = '0;
        wlen     = '0;
        unique case (rq)
            EV_BUS_RESET:
                p_hard = state_reg != ST_APP_IDLE && state_reg != ST_APP_DETACH &&
                         state_reg != ST_IDLE;
            EV_WR_BEGIN, EV_WR_DONE:
                p_hard = 1'b0;
            default:
            begin
                if (state_reg == ST_IDLE && rq == RQ_DNLOAD &&
                    req.block_length != '0 && req.alt_setting)
                    p_unlock = 1'b1;
                if (state_reg == ST_DN_IDLE && rq == RQ_DNLOAD && req.block_length == '0)
                    p_relock = 1'b1;
                if (state_reg == ST_DN_SYNC && rq == RQ_GETSTATUS)
                begin
                    if (!target_reg)
                    begin
                        p_ram = 1'b1;
                        waddr = ram_base_reg + fwlen_reg;
                        wlen  = bbytes_reg;
                    end
                    else if (lock_reg == LK_WAIT)
                    begin
                        p_wstart = 1'b1;
                        waddr    = flash_base_reg + fwlen_reg;
                        wlen     = bbytes_reg;
                    end
                end
            end
        endcase
    end

    // state registers, updated as each request moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            status_reg  <= STS_OK;
            timeout_reg <= '0;
            target_reg  <= 1'b0;
            lock_reg    <= LK_WAIT;
            fwlen_reg   <= '0;
            bbytes_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            timeout_reg <= timeout_next;
            target_reg  <= target_next;
            lock_reg    <= lock_next;
            fwlen_reg   <= fwlen_next;
            bbytes_reg  <= bbytes_next;
        end
    end

    // result assembly
    always_comb
    begin
        result.state             = state_next;
        result.status            = status_next;
        result.ok                = status_next == STS_OK;
        result.timeout           = timeout_next;
        result.copy_to_ram       = p_ram;
        result.flash_unlock      = p_unlock;
        result.flash_relock      = p_relock;
        result.flash_write_start = p_wstart;
        result.write_address     = waddr;
        result.write_length      = wlen;
        result.hard_reset        = p_hard;
    end

endmodule

// ----- rtl/dfu_out_reg.sv -----
// result register stage with valid/ready toward the consumer
// depends on dfu_pkg
module dfu_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s1_valid,
    input  dfu_pkg::dfu_result_t result_in,
    output logic                 advance,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dfu_pkg::dfu_result_t result_out
);
    import dfu_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dfu_result_t result_reg;

    // take a new result when the register is empty or being drained
    assign advance = s1_valid && (!valid_reg || out_ready);

    always_comb
    begin
        if (advance)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- rtl/dfu_request_state_machine_unit.sv -----
// dfu request state machine top level: input register, fsm, result register
// depends on dfu_pkg, dfu_in_reg, dfu_fsm, dfu_out_reg
// path: an accepted request is held in the input register, then its result in the result register
// throughput: one request per cycle while the result register is not stalled
// reset: asynchronous active low; state idle, status ok, counters and bases zero
module dfu_request_state_machine_unit #(
    parameter int MAX_BLOCK = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [10:0] block_length,
    input  logic        alt_setting,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  dfu_state,
    output logic [1:0]  status_code,
    output logic        request_ok,
    output logic [8:0]  poll_timeout,
    output logic        copy_to_ram,
    output logic        flash_unlock,
    output logic        flash_relock,
    output logic        flash_write_start,
    output logic [31:0] write_address,
    output logic [10:0] write_length,
    output logic        hard_reset
);
    import dfu_pkg::*;

    dfu_req_t    req_in;
    dfu_req_t    req_s1;
    logic        s1_valid;
    logic        advance;
    dfu_result_t result_s1;
    dfu_result_t result_out;

    assign req_in.req_type     = req_type;
    assign req_in.block_length = block_length;
    assign req_in.alt_setting  = alt_setting;

    // input register
    dfu_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_in   (req_in),
        .advance  (advance),
        .s1_valid (s1_valid),
        .req_out  (req_s1)
    );

    // state machine
    dfu_fsm #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .req       (req_s1),
        .result    (result_s1)
    );

    // result register
    dfu_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .result_in  (result_s1),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign dfu_state         = result_out.state;
    assign status_code       = result_out.status;
    assign request_ok        = result_out.ok;
    assign poll_timeout      = result_out.timeout;
    assign copy_to_ram       = result_out.copy_to_ram;
    assign flash_unlock      = result_out.flash_unlock;
    assign flash_relock      = result_out.flash_relock;
    assign flash_write_start = result_out.flash_write_start;
    assign write_address     = result_out.write_address;
    assign write_length      = result_out.write_length;
    assign hard_reset        = result_out.hard_reset;

endmodule

// ----- rtl/dfu_checker.sv -----
// port-level checks for the dfu request state machine, bound to the top level
// depends on dfu_pkg and dfu_request_state_machine_unit
module dfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  dfu_state,
    input logic [1:0]  status_code,
    input logic        request_ok,
    input logic        copy_to_ram,
    input logic        flash_unlock,
    input logic        flash_relock,
    input logic        flash_write_start,
    input logic [31:0] write_address,
    input logic [10:0] write_length,
    input logic        hard_reset
);
    import dfu_pkg::*;

    // ok flag tracks the status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (request_ok == (status_code == STS_OK)))
        else $error("request_ok disagrees with status_code");

    // write window is zero without a copy or write pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !copy_to_ram && !flash_write_start) |->
        (write_address == '0 && write_length == '0))
        else $error("write window set without a copy or write pulse");

    // one action pulse per result at most
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({copy_to_ram, flash_unlock, flash_relock,
                                flash_write_start, hard_reset}))
        else $error("more than one action pulse in a result");

    // hard reset lands in idle with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hard_reset) |-> (dfu_state == ST_IDLE && status_code == STS_OK))
        else $error("hard reset result not idle and ok");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(dfu_state) &&
                                       $stable(status_code)))
        else $error("stalled result changed");

endmodule

bind dfu_request_state_machine_unit dfu_checker u_dfu_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// self-checking bench for the dfu request state machine: queued requests, scored results
// depends on dfu_pkg and dfu_request_state_machine_unit from the rtl folder
module testbench;
    import dfu_pkg::*;

    localparam int MAX_BLOCK   = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 5;
    localparam int PER_PHASE   = 240;

    // clock, reset and block ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  req_type = '0;
    logic [10:0] block_length = '0;
    logic        alt_setting = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  dfu_state;
    logic [1:0]  status_code;
    logic        request_ok;
    logic [8:0]  poll_timeout;
    logic        copy_to_ram;
    logic        flash_unlock;
    logic        flash_relock;
    logic        flash_write_start;
    logic [31:0] write_address;
    logic [10:0] write_length;
    logic        hard_reset;

    // stimulus and scoreboard storage
    dfu_req_t    pending_requests[$];
    dfu_result_t expected_results[$];
    dfu_req_t    taken_req;
    dfu_req_t    next_req;
    dfu_result_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_queued       = 0;
    int n_accepted     = 0;
    int n_checked      = 0;
    int n_mismatch     = 0;
    int n_ram_copies   = 0;
    int n_flash_writes = 0;
    int n_hard_resets  = 0;
    int cycle_count    = 0;

    // device state as the bench tracks it
    dfu_state_t  dev_state     = ST_IDLE;
    status_t     dev_status    = STS_OK;
    logic [8:0]  dev_timeout   = '0;
    logic        dev_to_flash  = 1'b0;
    lock_t       dev_lock      = LK_WAIT;
    logic [31:0] dev_fw_len    = '0;
    logic [10:0] dev_blk_bytes = '0;
    logic [31:0] dev_ram_base  = '0;
    logic [31:0] dev_flash_base = '0;

    dfu_request_state_machine_unit #(
        .MAX_BLOCK(MAX_BLOCK)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .block_length      (block_length),
        .alt_setting       (alt_setting),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .dfu_state         (dfu_state),
        .status_code       (status_code),
        .request_ok        (request_ok),
        .poll_timeout      (poll_timeout),
        .copy_to_ram       (copy_to_ram),
        .flash_unlock      (flash_unlock),
        .flash_relock      (flash_relock),
        .flash_write_start (flash_write_start),
        .write_address     (write_address),
        .write_length      (write_length),
        .hard_reset        (hard_reset)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // any request in a state with no rule for it
    function automatic void enter_error();
        dev_state  = ST_ERROR;
        dev_status = STS_STALL;
    endfunction

    // flash block fully written: keep only the timeout high bit
    function automatic void close_flash_block();
        dev_timeout = dev_timeout & TIMEOUT_KEEP;
        dev_lock    = LK_WAIT;
        dev_state   = ST_DN_IDLE;
    endfunction

    // next device state and the result one request produces
    function automatic dfu_result_t predict_result(dfu_req_t r);
        dfu_result_t res;
        req_t        code;
        logic [10:0] clamped;
        res     = '0;
        code    = (r.req_type > EV_WR_DONE) ? RQ_OTHER : req_t'(r.req_type);
        clamped = (r.block_length > MAX_BLOCK) ? 11'(MAX_BLOCK) : r.block_length;

        if (code == EV_BUS_RESET)
        begin
            dev_fw_len = '0;
            if (dev_state == ST_APP_DETACH)
            begin
                dev_state  = ST_IDLE;
                dev_status = STS_OK;
            end
            else if (dev_state != ST_APP_IDLE && dev_state != ST_IDLE)
            begin
                dev_state      = ST_IDLE;
                dev_status     = STS_OK;
                res.hard_reset = 1'b1;
            end
        end
        else if (code == EV_WR_BEGIN)
        begin
            if (dev_to_flash && dev_lock == LK_BEGIN)
                dev_lock = LK_MIDDLE;
        end
        else if (code == EV_WR_DONE)
        begin
            if (dev_to_flash && dev_lock == LK_MIDDLE)
            begin
                dev_fw_len    = dev_fw_len + 32'(dev_blk_bytes);
                dev_blk_bytes = '0;
                dev_lock      = LK_END;
            end
        end
        else
        begin
            dev_status = STS_OK;
            case (dev_state)
                ST_IDLE:
                begin
                    if (code == RQ_DNLOAD)
                    begin
                        if (r.block_length != 0)
                        begin
                            dev_fw_len       = '0;
                            dev_blk_bytes    = clamped;
                            dev_state        = ST_DN_SYNC;
                            dev_to_flash     = r.alt_setting;
                            res.flash_unlock = r.alt_setting;
                        end
                        else
                        begin
                            dev_state  = ST_ERROR;
                            dev_status = STS_NOTDONE;
                        end
                    end
                    else if (code == RQ_UPLOAD)
                        dev_state = ST_UP_IDLE;
                    else if (code == RQ_ABORT || code == RQ_GETSTATUS || code == RQ_GETSTATE)
                        dev_state = ST_IDLE;
                    else
                        enter_error();
                end
                ST_DN_SYNC:
                begin
                    if (code == RQ_GETSTATUS)
                    begin
                        if (dev_to_flash)
                        begin
                            if (dev_lock == LK_WAIT)
                            begin
                                dev_lock              = LK_BEGIN;
                                dev_timeout           = TIMEOUT_FULL;
                                dev_state             = ST_DN_BUSY;
                                res.flash_write_start = 1'b1;
                                res.write_address     = dev_flash_base + dev_fw_len;
                                res.write_length      = dev_blk_bytes;
                            end
                            else if (dev_lock == LK_END)
                                close_flash_block();
                        end
                        else
                        begin
                            dev_state         = ST_DN_IDLE;
                            res.copy_to_ram   = 1'b1;
                            res.write_address = dev_ram_base + dev_fw_len;
                            res.write_length  = dev_blk_bytes;
                            dev_fw_len        = dev_fw_len + 32'(dev_blk_bytes);
                            dev_blk_bytes     = '0;
                        end
                    end
                    else if (code != RQ_GETSTATE)
                        enter_error();
                end
                ST_DN_BUSY:
                begin
                    if (dev_lock == LK_END)
                        close_flash_block();
                end
                ST_DN_IDLE:
                begin
                    if (code == RQ_DNLOAD)
                    begin
                        if (r.block_length != 0)
                        begin
                            dev_blk_bytes = clamped;
                            dev_state     = ST_DN_SYNC;
                        end
                        else
                        begin
                            dev_state        = ST_MAN_SYNC;
                            res.flash_relock = 1'b1;
                        end
                    end
                    else if (code == RQ_ABORT || code == RQ_GETSTATUS || code == RQ_GETSTATE)
                        dev_state = ST_IDLE;
                    else
                        enter_error();
                end
                ST_MAN_SYNC:
                begin
                    if (code == RQ_GETSTATUS)
                        dev_state = ST_WAIT_RESET;
                    else if (code != RQ_GETSTATE)
                        enter_error();
                end
                ST_MANIFEST:
                    dev_state = ST_WAIT_RESET;
                ST_WAIT_RESET:
                    ;
                ST_UP_IDLE:
                begin
                    if (code == RQ_ABORT)
                        dev_state = ST_IDLE;
                    else if (code != RQ_GETSTATUS && code != RQ_GETSTATE)
                        enter_error();
                end
                ST_ERROR:
                begin
                    if (code == RQ_CLRSTATUS)
                        dev_state = ST_IDLE;
                    else if (code != RQ_GETSTATUS && code != RQ_GETSTATE)
                        enter_error();
                end
                default:
                    enter_error();
            endcase
        end

        res.state   = dev_state;
        res.status  = dev_status;
        res.ok      = (dev_status == STS_OK);
        res.timeout = dev_timeout;
        return res;
    endfunction

    // print one mismatch line and count it
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        n_mismatch++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h want %0h (result %0d)",
                                      name, got, exp_val, n_checked));
    endtask

    task automatic queue_request(input logic [3:0] code, input int len, input bit alt);
        dfu_req_t r;
        r.req_type     = code;
        r.block_length = 11'(len);
        r.alt_setting  = alt;
        pending_requests.push_back(r);
        n_queued++;
    endtask

    // mostly short blocks, some up to full size, a few oversized
    function automatic int rand_block_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(1, 64);
        if (pick < 9)
            return $urandom_range(1, MAX_BLOCK);
        return $urandom_range(MAX_BLOCK + 1, 2047);
    endfunction

    task automatic queue_noise(input int count);
        for (int i = 0; i < count; i++)
            queue_request(4'($urandom_range(0, 15)), $urandom_range(0, 2047),
                          1'($urandom_range(0, 1)));
    endtask

    // one host session: a download, an upload or a burst of noise
    task automatic queue_session();
        int  kind;
        int  nblk;
        int  ending;
        bit  to_flash;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            queue_noise($urandom_range(1, 6));
        end
        else if (kind == 2)
        begin
            queue_request(RQ_UPLOAD, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3))
                queue_request($urandom_range(0, 1) ? RQ_GETSTATUS : RQ_GETSTATE,
                              $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
            queue_request(RQ_ABORT, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
        end
        else
        begin
            to_flash = 1'($urandom_range(0, 1));
            nblk     = $urandom_range(1, 4);
            queue_request(RQ_DNLOAD, rand_block_len(), to_flash);
            for (int b = 0; b < nblk; b++)
            begin
                if ($urandom_range(0, 19) == 0)
                    queue_noise(1);
                if (to_flash)
                begin
                    queue_request(RQ_GETSTATUS, $urandom_range(0, 2047), to_flash);
                    queue_request(EV_WR_BEGIN, $urandom_range(0, 2047), to_flash);
                    if ($urandom_range(0, 2) == 0)
                        queue_request(RQ_GETSTATUS, $urandom_range(0, 2047), to_flash);
                    queue_request(EV_WR_DONE, $urandom_range(0, 2047), to_flash);
                    queue_request(RQ_GETSTATUS, $urandom_range(0, 2047), to_flash);
                end
                else
                begin
                    queue_request(RQ_GETSTATUS, $urandom_range(0, 2047), to_flash);
                end
                if (b < nblk - 1)
                    queue_request(RQ_DNLOAD, rand_block_len(), 1'($urandom_range(0, 1)));
            end
            ending = $urandom_range(0, 19);
            if (ending < 14)
            begin
                queue_request(RQ_DNLOAD, 0, 1'($urandom_range(0, 1)));
                queue_request(RQ_GETSTATUS, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
                queue_request(EV_BUS_RESET, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
            end
            else if (ending < 17)
            begin
                queue_request(RQ_ABORT, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
            end
            else
            begin
                queue_request(EV_BUS_RESET, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // directed corner cases of the state machine, in one pass
    task automatic queue_directed();
        queue_request(RQ_GETSTATE, 0, 1'b0);
        queue_request(RQ_UPLOAD, 2047, 1'b1);
        queue_request(RQ_GETSTATUS, 0, 1'b0);
        queue_request(RQ_OTHER, 0, 1'b0);
        queue_request(RQ_GETSTATUS, 0, 1'b0);
        queue_request(RQ_CLRSTATUS, 0, 1'b0);
        queue_request(RQ_DNLOAD, 0, 1'b0);
        queue_request(4'hF, 2047, 1'b1);
        queue_request(EV_BUS_RESET, 0, 1'b0);
        queue_request(RQ_DNLOAD, 2047, 1'b0);
        queue_request(RQ_GETSTATUS, 0, 1'b0);
        queue_request(RQ_DNLOAD, 1, 1'b0);
        queue_request(RQ_GETSTATUS, 0, 1'b0);
        queue_request(RQ_DNLOAD, 0, 1'b0);
        queue_request(RQ_GETSTATUS, 0, 1'b0);
        queue_request(EV_BUS_RESET, 2047, 1'b1);
        queue_request(RQ_DNLOAD, MAX_BLOCK, 1'b1);
        queue_request(EV_WR_BEGIN, 0, 1'b1);
        queue_request(RQ_GETSTATUS, 0, 1'b1);
        queue_request(EV_WR_BEGIN, 0, 1'b1);
        queue_request(EV_WR_DONE, 0, 1'b1);
        queue_request(RQ_GETSTATUS, 0, 1'b1);
        queue_request(RQ_ABORT, 0, 1'b1);
        queue_request(RQ_CLRSTATUS, 0, 1'b0);
        queue_request(EV_BUS_RESET, 0, 1'b0);
    endtask

    // block is idle once every queued request has come back
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bases(input logic [31:0] ram, input logic [31:0] flash);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RAM_BASE;
        cfg_data  <= ram;
        @(posedge clk);
        cfg_index <= CFG_FLASH_BASE;
        cfg_data  <= flash;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dev_ram_base   = ram;
        dev_flash_base = flash;
    endtask

    // request driver: predicts on accept, then presents the next pending request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken_req.req_type     = req_type;
                taken_req.block_length = block_length;
                taken_req.alt_setting  = alt_setting;
                expected_results.push_back(predict_result(taken_req));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid     <= 1'b1;
                    req_type     <= next_req.req_type;
                    block_length <= next_req.block_length;
                    alt_setting  <= next_req.alt_setting;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: scores each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("dfu_state", dfu_state, want.state);
                    check_field("status_code", status_code, want.status);
                    check_field("request_ok", request_ok, want.ok);
                    check_field("poll_timeout", poll_timeout, want.timeout);
                    check_field("copy_to_ram", copy_to_ram, want.copy_to_ram);
                    check_field("flash_unlock", flash_unlock, want.flash_unlock);
                    check_field("flash_relock", flash_relock, want.flash_relock);
                    check_field("flash_write_start", flash_write_start,
                                want.flash_write_start);
                    check_field("write_address", write_address, want.write_address);
                    check_field("write_length", write_length, want.write_length);
                    check_field("hard_reset", hard_reset, want.hard_reset);
                    n_ram_copies   += want.copy_to_ram;
                    n_flash_writes += want.flash_write_start;
                    n_hard_resets  += want.hard_reset;
                end
                n_checked++;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // reset, then one phase per base setting and idling mix
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_until_drained();
            case (ph)
                0: write_bases(32'h2000_0C00, 32'h0800_5000);
                1: write_bases(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: write_bases(32'h0000_0000, 32'h0000_0000);
                3: write_bases($urandom, $urandom);
                default: write_bases(32'hFFFF_FC00, 32'hFFFF_F800);
            endcase
            // idling mix for this phase
            case (ph)
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 0)
                queue_directed();
            for (int target = n_queued + PER_PHASE; n_queued < target; )
                queue_session();
        end
        wait_until_drained();
        repeat (8) @(posedge clk);

        $display("summary: %0d requests over %0d phases, %0d results checked",
                 n_accepted, PHASES, n_checked);
        $display("summary: %0d ram copies, %0d flash writes, %0d hard resets, %0d mismatches",
                 n_ram_copies, n_flash_writes, n_hard_resets, n_mismatch);
        if (n_mismatch == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- dfu_request_state_machine_unit.f -----
rtl/dfu_pkg.sv
rtl/dfu_in_reg.sv
rtl/dfu_fsm.sv
rtl/dfu_out_reg.sv
rtl/dfu_request_state_machine_unit.sv
rtl/dfu_checker.sv
verif/testbench.sv
